FILE: design/tps_pkg.sv
// Package: shared types and constants for the timed power sequencer.
package tps_pkg;

  // Command codes carried in a result item
  localparam logic [2:0] CMD_A       = 3'd0;
  localparam logic [2:0] CMD_B       = 3'd1;
  localparam logic [2:0] CMD_PROJ    = 3'd2;
  localparam logic [2:0] CMD_AMP_PWR = 3'd3;
  localparam logic [2:0] CMD_AMP_SEL = 3'd4;

  // Fixed gaps in milliseconds
  localparam logic [15:0] RELAY_GAP_MS = 16'd500;
  localparam logic [15:0] AMP_GAP_MS   = 16'd1000;
  localparam logic [15:0] SEL_GAP_MS   = 16'd0;
  localparam logic [15:0] PROJ_GAP_RESET_MS = 16'd1000;

  // Scan slots of an apply: A relays, then B relays, projector, amplifier
  localparam logic [3:0] SLOT_B_FIRST = 4'd8;
  localparam logic [3:0] SLOT_PROJ    = 4'd13;
  localparam logic [3:0] SLOT_AMP     = 4'd14;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  id;
    logic        lvl;
    logic [15:0] gap;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_POP
  } state_e;

  typedef struct packed {
    logic start_apply;
    logic tick;
    logic scan;
    logic load_out;
  } tps_cmd_t;

  typedef struct packed {
    logic pop_now;
    logic scan_last;
    logic out_free;
  } tps_status_t;

endpackage

FILE: design/tps_in_if.sv
// Interface: input item channel of the timed power sequencer.
interface tps_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] relay_a_target;
  logic [4:0] relay_b_target;
  logic       projector_target;
  logic [7:0] amp_input_target;

  modport source (
    output valid, func, relay_a_target, relay_b_target, projector_target, amp_input_target,
    input  ready
  );
  modport sink (
    input  valid, func, relay_a_target, relay_b_target, projector_target, amp_input_target,
    output ready
  );
endinterface

FILE: design/tps_out_if.sv
// Interface: result item channel of the timed power sequencer.
interface tps_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] target_id;
  logic       level;
  logic [7:0] start_input;

  modport source (
    output valid, command, target_id, level, start_input,
    input  ready
  );
  modport sink (
    input  valid, command, target_id, level, start_input,
    output ready
  );
endinterface

FILE: design/tps_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tps_ram #(
  parameter int Width = 28,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/tps_ctrl.sv
// Controller state machine: sequences apply scans and command pops.
module tps_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_func_i,
  output logic                in_ready_o,
  input  tps_pkg::tps_status_t status_i,
  output tps_pkg::tps_cmd_t    cmd_o
);
  import tps_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_func_i) begin
            state_d = ST_SCAN;
          end else if (status_i.pop_now) begin
            state_d = ST_POP;
          end
        end
      end
      ST_SCAN: begin
        if (status_i.scan_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_POP: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o        = 1'b0;
    cmd_o             = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o        = 1'b1;
        cmd_o.start_apply = accept && in_func_i;
        cmd_o.tick        = accept && !in_func_i;
      end
      ST_SCAN: cmd_o.scan = 1'b1;
      ST_POP:  cmd_o.load_out = status_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

FILE: design/tps_datapath.sv
// Datapath: present state, command ring, wait counter and result register.
module tps_datapath #(
  parameter int RING_DEPTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i,
  input  logic [7:0]           relay_a_target_i,
  input  logic [4:0]           relay_b_target_i,
  input  logic                 projector_target_i,
  input  logic [7:0]           amp_input_target_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2:0]           command_o,
  output logic [7:0]           target_id_o,
  output logic                 level_o,
  output logic [7:0]           start_input_o,
  input  tps_pkg::tps_cmd_t    cmd_i,
  output tps_pkg::tps_status_t status_o
);
  import tps_pkg::*;

  localparam int PtrW = $clog2(RING_DEPTH);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(RING_DEPTH - 1);

  logic [15:0]     proj_gap_q;
  logic [7:0]      pres_a_q;
  logic [4:0]      pres_b_q;
  logic            pres_proj_q;
  logic            pres_amp_on_q;
  logic [7:0]      pres_amp_in_q;
  logic [7:0]      tgt_a_q;
  logic [4:0]      tgt_b_q;
  logic            tgt_proj_q;
  logic [7:0]      tgt_amp_in_q;
  logic [PtrW-1:0] head_q, tail_q, head_next, tail_next;
  logic            running_q;
  logic [15:0]     wait_q, wait_cur, wait_dec;
  logic [3:0]      slot_q;
  logic            out_valid_q;
  logic [2:0]      out_cmd_q;
  logic [7:0]      out_id_q;
  logic            out_lvl_q;
  logic [7:0]      out_start_q;

  logic            ring_empty, ring_full;
  logic            push_en, ram_we;
  entry_t          push_entry, rd_entry;
  logic [2:0]      a_idx, b_idx;
  logic [3:0]      b_off;

  assign head_next  = (head_q == PtrLast) ? '0 : head_q + 1'b1;
  assign tail_next  = (tail_q == PtrLast) ? '0 : tail_q + 1'b1;
  assign ring_empty = (head_q == tail_q);
  assign ring_full  = (tail_next == head_q);

  // Wait seen by a tick: cleared when the ring was not yet running
  assign wait_cur = running_q ? wait_q : '0;
  assign wait_dec = (wait_cur != '0) ? wait_cur - 16'd1 : '0;

  assign status_o.pop_now   = !ring_empty && (wait_dec == '0);
  assign status_o.scan_last = (slot_q == SLOT_AMP);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  // Candidate command for the current scan slot
  assign a_idx = slot_q[2:0];
  assign b_off = slot_q - SLOT_B_FIRST;
  assign b_idx = b_off[2:0];

  always_comb begin
    push_en    = 1'b0;
    push_entry = '0;
    if (slot_q < SLOT_B_FIRST) begin
      push_en    = tgt_a_q[a_idx] != pres_a_q[a_idx];
      push_entry = '{cmd: CMD_A, id: {5'd0, a_idx} + 8'd1, lvl: tgt_a_q[a_idx],
                     gap: RELAY_GAP_MS};
    end else if (slot_q < SLOT_PROJ) begin
      push_en    = tgt_b_q[b_idx] != pres_b_q[b_idx];
      push_entry = '{cmd: CMD_B, id: {5'd0, b_idx} + 8'd1, lvl: tgt_b_q[b_idx],
                     gap: RELAY_GAP_MS};
    end else if (slot_q == SLOT_PROJ) begin
      push_en    = tgt_proj_q != pres_proj_q;
      push_entry = '{cmd: CMD_PROJ, id: 8'd0, lvl: tgt_proj_q, gap: proj_gap_q};
    end else if (!pres_amp_on_q) begin
      push_en    = 1'b1;
      push_entry = '{cmd: CMD_AMP_PWR, id: 8'd0, lvl: 1'b1, gap: AMP_GAP_MS};
    end else begin
      push_en    = tgt_amp_in_q != pres_amp_in_q;
      push_entry = '{cmd: CMD_AMP_SEL, id: tgt_amp_in_q, lvl: 1'b1, gap: SEL_GAP_MS};
    end
  end

  assign ram_we = cmd_i.scan && push_en && !ring_full;

  tps_ram #(
    .Width ($bits(entry_t)),
    .Depth (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (push_entry),
    .re_i    (cmd_i.tick && status_o.pop_now),
    .raddr_i (head_q),
    .rdata_o (rd_entry)
  );

  // Control and present state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proj_gap_q    <= PROJ_GAP_RESET_MS;
      pres_a_q      <= '0;
      pres_b_q      <= '0;
      pres_proj_q   <= 1'b0;
      pres_amp_on_q <= 1'b0;
      pres_amp_in_q <= '0;
      head_q        <= '0;
      tail_q        <= '0;
      running_q     <= 1'b0;
      wait_q        <= '0;
      slot_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        proj_gap_q <= cfg_wdata_i;
      end
      if (cmd_i.start_apply) begin
        head_q    <= '0;
        tail_q    <= '0;
        running_q <= 1'b0;
        slot_q    <= '0;
      end
      if (cmd_i.scan) begin
        slot_q <= slot_q + 4'd1;
        if (ram_we) begin
          tail_q <= tail_next;
        end
        if (status_o.scan_last) begin
          pres_a_q      <= tgt_a_q;
          pres_b_q      <= tgt_b_q;
          pres_proj_q   <= tgt_proj_q;
          pres_amp_on_q <= 1'b1;
          pres_amp_in_q <= tgt_amp_in_q;
        end
      end
      if (cmd_i.tick) begin
        if (ring_empty) begin
          running_q <= 1'b0;
        end else begin
          running_q <= 1'b1;
          wait_q    <= wait_dec;
          if (status_o.pop_now) begin
            head_q <= head_next;
          end
        end
      end
      if (cmd_i.load_out) begin
        wait_q      <= rd_entry.gap;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_apply) begin
      tgt_a_q      <= relay_a_target_i;
      tgt_b_q      <= relay_b_target_i;
      tgt_proj_q   <= projector_target_i;
      tgt_amp_in_q <= amp_input_target_i;
    end
    if (cmd_i.load_out) begin
      out_cmd_q   <= rd_entry.cmd;
      out_id_q    <= rd_entry.id;
      out_lvl_q   <= rd_entry.lvl;
      out_start_q <= (rd_entry.cmd == CMD_AMP_PWR && rd_entry.lvl) ? pres_amp_in_q : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign command_o     = out_cmd_q;
  assign target_id_o   = out_id_q;
  assign level_o       = out_lvl_q;
  assign start_input_o = out_start_q;

endmodule

FILE: design/timed_power_sequencer.sv
// Top level: timed power sequencer for relays, projector and amplifier.
//
//   Channel   Dir  Handshake      Carries
//   item_i    in   valid/ready    func, relay_a/b_target, projector_target,
//                                 amp_input_target
//   result_o  out  valid/ready    command, target_id, level, start_input
//   cfg       in   cfg_we_i       projector_gap_ms (16 bit), no read-back
//
// Sequencing: an apply item is accepted, then runs a 15-slot scan that
// pushes at most one command per cycle through the ring RAM write port.
// A tick that pops is accepted with the RAM read, then loads the result
// register from the registered read data. Any other tick ends on its accept.
// Reset: asynchronous, active low; clears the pointers, the wait counter and
// the present scene, and loads the projector gap with 1000. The ring RAM is
// not cleared: only entries written since the last apply are ever read.
// Stalls: a stalled result holds only a popping tick, in its load cycle;
// applies and non-popping ticks proceed while a result waits.
module timed_power_sequencer #(
  parameter int RING_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  tps_in_if.sink      item_i,
  tps_out_if.source   result_o
);
  import tps_pkg::*;

  tps_cmd_t    cmd;
  tps_status_t status;

  // Sequence each accepted item
  tps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_func_i  (item_i.func),
    .in_ready_o (item_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Hold the scene, the ring and the result
  tps_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .relay_a_target_i   (item_i.relay_a_target),
    .relay_b_target_i   (item_i.relay_b_target),
    .projector_target_i (item_i.projector_target),
    .amp_input_target_i (item_i.amp_input_target),
    .out_valid_o        (result_o.valid),
    .out_ready_i        (result_o.ready),
    .command_o          (result_o.command),
    .target_id_o        (result_o.target_id),
    .level_o            (result_o.level),
    .start_input_o      (result_o.start_input),
    .cmd_i              (cmd),
    .status_o           (status)
  );

endmodule
